// ===== hdl/asb_pkg.sv =====
// Shared constants, segment glyph table and rewiring function for the
// ASCII seven-segment shift buffer. No dependencies.
`default_nettype none

package asb_pkg;

  localparam int unsigned SEG_W    = 8;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned ORDER_W  = 32;
  localparam int unsigned OUT_DIGS = 4;
  localparam int unsigned TAB_W    = 3;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 32'h7654_3210;

  localparam logic REQ_CHAR  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic [CODE_W-1:0] CODE_TAB        = 8'd9;
  localparam logic [CODE_W-1:0] CODE_NEWLINE    = 8'd10;
  localparam logic [CODE_W-1:0] CODE_PERIOD     = 8'd46;
  localparam logic [CODE_W-1:0] FIRST_PRINTABLE = 8'd32;
  localparam logic [CODE_W-1:0] LAST_PRINTABLE  = 8'd126;

  localparam logic [TAB_W-1:0] TAB_STOP = 3'd4;

  localparam int unsigned GLYPH_N = 95;

  // Segments a..g, dp from bit 7 down to bit 0
  localparam logic [SEG_W-1:0] GLYPH_TABLE [GLYPH_N] = '{
    8'h00, 8'h41, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04,
    8'h9c, 8'hf0, 8'h00, 8'h00, 8'h08, 8'h02, 8'h01, 8'h4a,
    8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66, 8'hb6, 8'hbe, 8'he0,
    8'hfe, 8'hf6, 8'h00, 8'h00, 8'h86, 8'h12, 8'hc2, 8'hca,
    8'h00, 8'hee, 8'hfe, 8'h9c, 8'h7a, 8'h9e, 8'h8e, 8'hbe,
    8'h6e, 8'h0c, 8'h78, 8'h9c, 8'h1c, 8'h00, 8'hec, 8'hfc,
    8'hce, 8'he6, 8'h0a, 8'hb6, 8'he0, 8'h7c, 8'h7c, 8'h00,
    8'h6e, 8'h76, 8'hda, 8'h9c, 8'h26, 8'hf0, 8'hc4, 8'h10,
    8'h04, 8'hee, 8'h3e, 8'h1a, 8'h7a, 8'hde, 8'h8e, 8'hf6,
    8'h2e, 8'h08, 8'h78, 8'h1a, 8'h0c, 8'h00, 8'h2a, 8'h3a,
    8'hce, 8'he6, 8'h0a, 8'hb6, 8'h62, 8'h38, 8'h38, 8'h00,
    8'h6e, 8'h76, 8'hda, 8'h9c, 8'h0c, 8'hf0, 8'h80
  };

  // Blank for anything outside the printable range
  function automatic logic [SEG_W-1:0] glyph(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] offs;
    offs = code - FIRST_PRINTABLE;
    if (code >= FIRST_PRINTABLE && code <= LAST_PRINTABLE) begin
      return GLYPH_TABLE[offs[6:0]];
    end
    return '0;
  endfunction

  // Nibble j of order drives output bit 7-j; values 8..15 leave it off
  function automatic logic [SEG_W-1:0] rewire(input logic [SEG_W-1:0] pattern,
                                              input logic [ORDER_W-1:0] order);
    logic [SEG_W-1:0] res;
    logic [3:0]       sel;
    res = '0;
    for (int j = 0; j < 8; j++) begin
      sel = order[4*j +: 4];
      if (!sel[3] && pattern[~sel[2:0]]) begin
        res[3'(7 - j)] = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/asb_if.sv =====
// Channel interfaces for the ASCII seven-segment shift buffer: character
// input, digit output and segment order write. Depends on asb_pkg.
`default_nettype none

interface asb_in_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [asb_pkg::CODE_W-1:0]   char_code;

  modport source (output valid, req_type, char_code, input ready);
  modport sink   (input valid, req_type, char_code, output ready);
endinterface

interface asb_out_if;
  logic                         valid;
  logic                         ready;
  logic [asb_pkg::SEG_W-1:0]    digit_oldest;
  logic [asb_pkg::SEG_W-1:0]    digit_second;
  logic [asb_pkg::SEG_W-1:0]    digit_third;
  logic [asb_pkg::SEG_W-1:0]    digit_newest;

  modport source (output valid, digit_oldest, digit_second, digit_third, digit_newest,
                  input ready);
  modport sink   (input valid, digit_oldest, digit_second, digit_third, digit_newest,
                  output ready);
endinterface

interface asb_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [asb_pkg::ORDER_W-1:0]  segment_order;

  modport source (output valid, segment_order, input ready);
  modport sink   (input valid, segment_order, output ready);
endinterface

`default_nettype wire

// ===== hdl/ascii_seven_segment_shift_buffer_top.sv =====
// Top level of the ASCII seven-segment shift buffer: input register, one
// pass of decode/shift logic, digit store acting as the result register.
// Depends on asb_pkg and the channel interfaces in asb_if.sv.
//
// Path: an accepted transfer is held in the input register, then moves into the digit store, which presents it.
// Throughput: one character per cycle; the input register and the digit store
// with its valid flag form a two-deep pipeline that stalls only on output ready.
// Reset: asynchronous, active low; clears the digit store, column, content flag,
// segment order (to 0x76543210) and both valid flags. No clearing pass.
`default_nettype none

module ascii_seven_segment_shift_buffer_top #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  asb_cfg_if.sink     cfg_i,
  asb_in_if.sink      in_i,
  asb_out_if.source   out_o
);

  localparam int unsigned SEG_W = asb_pkg::SEG_W;

  // ------------------------------------------------------------------
  // Configuration: always ready; not enforced by the block, the user must ensure writes only happen while idle
  // ------------------------------------------------------------------
  logic [asb_pkg::ORDER_W-1:0] order_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= asb_pkg::ORDER_RESET;
    end else if (cfg_i.valid) begin
      order_q <= cfg_i.segment_order;
    end
  end

  // ------------------------------------------------------------------
  // Input register
  // ------------------------------------------------------------------
  logic                        s1_valid_q;
  logic                        s1_req_q;
  logic [asb_pkg::CODE_W-1:0]  s1_code_q;
  logic                        out_valid_q;
  logic                        advance;
  logic                        in_xfer;

  // Advance the held item into the store whenever the result slot is free
  // or is being drained this cycle.
  assign advance   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_req_q  <= in_i.req_type;
      s1_code_q <= in_i.char_code;
    end
  end

  // ------------------------------------------------------------------
  // Decode and shift: one pass over the held item
  // ------------------------------------------------------------------
  logic [SEG_W-1:0]        digit_q [DIGIT_COUNT];
  logic [SEG_W-1:0]        digit_d [DIGIT_COUNT];
  logic [1:0]              col_q, col_d;
  logic                    lhc_q, lhc_d;

  logic [SEG_W-1:0]        char_pat;
  logic [SEG_W-1:0]        dp_pat;
  logic [SEG_W-1:0]        newest;
  logic [asb_pkg::TAB_W-1:0] tab_cnt;
  logic                    merge_dp;
  logic [SEG_W-1:0]        push_pat;

  assign char_pat = asb_pkg::rewire(asb_pkg::glyph(s1_code_q), order_q);
  assign dp_pat   = asb_pkg::rewire(asb_pkg::glyph(asb_pkg::CODE_PERIOD), order_q);
  assign newest   = digit_q[DIGIT_COUNT-1];
  assign tab_cnt  = asb_pkg::TAB_STOP - {1'b0, col_q};

  // Fold a period into the newest digit only when the line has content and
  // the dp bits are not all lit there already; with no dp wiring it never merges.
  assign merge_dp = lhc_q && ((newest & dp_pat) != dp_pat);
  // Any other code, period included, pushes its wired pattern (blank if
  // unprintable)
  assign push_pat = char_pat;

  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      digit_d[i] = digit_q[i];
    end
    col_d = col_q;
    lhc_d = lhc_q;

    if (s1_req_q == asb_pkg::REQ_CLEAR) begin
      // Drop everything
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit_d[i] = '0;
      end
      col_d = '0;
      lhc_d = 1'b0;
    end else if (s1_code_q == asb_pkg::CODE_TAB) begin
      // Shift in blanks up to the next tab stop
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit_d[i] = '0;
        for (int k = 1; k <= 4; k++) begin
          if ((i + k < DIGIT_COUNT) && (tab_cnt == asb_pkg::TAB_W'(k))) begin
            digit_d[i] = digit_q[i + k];
          end
        end
      end
      col_d = '0;
      lhc_d = 1'b1;
    end else if (s1_code_q == asb_pkg::CODE_NEWLINE) begin
      col_d = '0;
      lhc_d = 1'b0;
    end else if ((s1_code_q == asb_pkg::CODE_PERIOD) && merge_dp) begin
      digit_d[DIGIT_COUNT-1] = newest | dp_pat;
    end else begin
      // Shift one digit in at the newest end
      for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
        digit_d[i] = digit_q[i + 1];
      end
      digit_d[DIGIT_COUNT-1] = push_pat;
      col_d = col_q + 2'd1;
      lhc_d = 1'b1;
    end
  end

  // ------------------------------------------------------------------
  // Digit store doubles as the result register
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit_q[i] <= '0;
      end
      col_q <= '0;
      lhc_q <= 1'b0;
    end else if (advance) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit_q[i] <= digit_d[i];
      end
      col_q <= col_d;
      lhc_q <= lhc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Show the four newest digits; slots beyond a short store read blank
  logic [SEG_W-1:0] shown [asb_pkg::OUT_DIGS];

  always_comb begin
    for (int k = 0; k < asb_pkg::OUT_DIGS; k++) begin
      shown[k] = '0;
      if (int'(DIGIT_COUNT) - int'(asb_pkg::OUT_DIGS) + k >= 0) begin
        shown[k] = digit_q[int'(DIGIT_COUNT) - int'(asb_pkg::OUT_DIGS) + k];
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.digit_oldest = shown[0];
  assign out_o.digit_second = shown[1];
  assign out_o.digit_third  = shown[2];
  assign out_o.digit_newest = shown[3];

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
`ifndef SYNTH
  // A held item is never dropped while the result side stalls
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q)
    else $error("held item lost during stall");

  // Line state moves only when an item advances
  a_state_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(col_q) && $stable(lhc_q) && $stable(digit_q[DIGIT_COUNT-1]))
    else $error("line state changed without an advancing item");

  // A clear leaves a blank newest digit and an empty line
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (s1_req_q == asb_pkg::REQ_CLEAR)
      |=> (digit_q[DIGIT_COUNT-1] == '0) && (col_q == '0) && !lhc_q && out_valid_q)
    else $error("clear did not empty the buffer");

  // Newline resets the column and keeps the digits
  a_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (s1_req_q == asb_pkg::REQ_CHAR) && (s1_code_q == asb_pkg::CODE_NEWLINE)
      |=> (col_q == '0) && !lhc_q && $stable(digit_q[DIGIT_COUNT-1]))
    else $error("newline mishandled");
`endif

endmodule

`default_nettype wire
